@@ hdl/assert_macros.svh @@
// assertion helpers used by the acep_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hdl/acep_pkg.sv @@
`default_nettype none

package acep_pkg;

	// parse phase codes
	localparam logic [1:0] PH_GROUND = 2'd0;
	localparam logic [1:0] PH_ESC    = 2'd1;
	localparam logic [1:0] PH_CSI    = 2'd2;

	// configuration register indexes
	localparam logic REG_WRAP_COL = 1'b0;
	localparam logic REG_WRAP_RET = 1'b1;

	localparam logic [7:0] WRAP_COL_RESET = 8'd44;
	localparam logic [7:0] WRAP_RET_RESET = 8'd1;

	localparam logic [7:0] GLYPH_MIN = 8'd32;
	localparam logic [7:0] GLYPH_MAX = 8'd126;

	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_M     = 8'h4d;
	localparam logic [7:0] CH_SAVE  = 8'h37;
	localparam logic [7:0] CH_REST  = 8'h38;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// csi final bytes
	localparam logic [7:0] CMD_CUU = 8'h41; // A
	localparam logic [7:0] CMD_CUD = 8'h42; // B
	localparam logic [7:0] CMD_CUF = 8'h43; // C
	localparam logic [7:0] CMD_CUB = 8'h44; // D
	localparam logic [7:0] CMD_CNL = 8'h45; // E
	localparam logic [7:0] CMD_CPL = 8'h46; // F
	localparam logic [7:0] CMD_CHA = 8'h47; // G
	localparam logic [7:0] CMD_VPA = 8'h64; // d
	localparam logic [7:0] CMD_CUP = 8'h48; // H
	localparam logic [7:0] CMD_HVP = 8'h66; // f
	localparam logic [7:0] CMD_SCP = 8'h73; // s
	localparam logic [7:0] CMD_RCP = 8'h75; // u

	function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [7:0] d);
		logic [8:0] s;
		s = {1'b0, v} + {1'b0, d};
		return s[8] ? 8'hff : s[7:0];
	endfunction

	function automatic logic [7:0] sat_sub(input logic [7:0] v, input logic [7:0] d);
		return (v > d) ? (v - d) : 8'd0;
	endfunction

	// value*10 + digit, clamped at 255
	function automatic logic [7:0] accumulate(input logic [7:0] v, input logic [3:0] digit);
		logic [11:0] n;
		n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'd0, digit};
		return (n > 12'd255) ? 8'hff : n[7:0];
	endfunction

endpackage

`default_nettype wire

@@ hdl/ansi_cursor_escape_parser.sv @@
// Terminal byte stream to glyph draw commands.
// Input channel: byte_valid / byte_stall carry one byte_in per beat.
// Output channel: draw_valid / draw_stall carry glyph_code, draw_column and
// draw_row per beat, one beat for each printable byte seen outside a sequence.
// Control bytes, ESC sequences and CSI sequences only update the cursor state.
// Config: cfg_write with cfg_index 0 sets wrap_column, 1 sets
// wrap_return_column; write only while no byte is in flight.
// Path: an accepted byte is held in the input register and decoded there;
// a printable byte's draw beat is loaded into the draw register as it advances.
// Throughput: one byte per cycle unless a printable byte waits behind a held
// draw beat; decode is a single pass of cursor logic between the input
// register and the draw register.
// Stall: the draw register holds its beat while draw_stall is high; a
// printable byte waiting behind a held beat raises byte_stall, other bytes
// keep flowing.
// Reset: cursor, saved cursor and parser return to ground at column 0,
// row 0; wrap_column resets to 44 and wrap_return_column to 1.
`default_nettype none

module ansi_cursor_escape_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] byte_in,
	output logic            draw_valid,
	input  wire logic       draw_stall,
	output logic [6:0]      glyph_code,
	output logic [7:0]      draw_column,
	output logic [7:0]      draw_row
);

	logic [7:0] wrap_col_q, wrap_ret_q;
	logic [1:0] phase_q, phase_d;
	logic [7:0] col_q, col_d, row_q, row_d;
	logic [7:0] scol_q, scol_d, srow_q, srow_d;
	logic [7:0] p1_q, p1_d, p2_q, p2_d;
	logic       in_p2_q, in_p2_d, digit_q, digit_d;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic       emit;
	logic       advance;
	logic       accept;
	logic [7:0] glyph_col, glyph_row;
	logic [7:0] p_val, q_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_col_q <= acep_pkg::WRAP_COL_RESET;
			wrap_ret_q <= acep_pkg::WRAP_RET_RESET;
		end else if (cfg_write) begin
			if (cfg_index == acep_pkg::REG_WRAP_COL)
				wrap_col_q <= cfg_data;
			else
				wrap_ret_q <= cfg_data;
		end
	end

	// input register
	assign accept     = byte_valid && !byte_stall;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_s1 <= byte_in;
	end

	// a byte with no draw beat never waits on the output side
	assign advance = valid_s1 && (!emit || !draw_valid || !draw_stall);

	always_comb begin
		p_val = digit_q ? p1_q : 8'd1;
		q_val = digit_q ? p2_q : 8'd1;
	end

	always_comb begin
		phase_d   = phase_q;
		col_d     = col_q;
		row_d     = row_q;
		scol_d    = scol_q;
		srow_d    = srow_q;
		p1_d      = p1_q;
		p2_d      = p2_q;
		in_p2_d   = in_p2_q;
		digit_d   = digit_q;
		emit      = 1'b0;
		glyph_col = col_q;
		glyph_row = row_q;
		unique case (phase_q)
			acep_pkg::PH_ESC: begin
				phase_d = acep_pkg::PH_GROUND;
				case (byte_s1)
					acep_pkg::CH_M: row_d = acep_pkg::sat_sub(row_q, 8'd1);
					acep_pkg::CH_SAVE: begin
						scol_d = col_q;
						srow_d = row_q;
					end
					acep_pkg::CH_REST: begin
						col_d = scol_q;
						row_d = srow_q;
					end
					acep_pkg::CH_LBRK: begin
						phase_d = acep_pkg::PH_CSI;
						p1_d    = 8'd0;
						p2_d    = 8'd0;
						in_p2_d = 1'b0;
						digit_d = 1'b0;
					end
					default: ;
				endcase
			end
			acep_pkg::PH_CSI: begin
				if (byte_s1 >= acep_pkg::CH_ZERO && byte_s1 <= acep_pkg::CH_NINE) begin
					if (in_p2_q)
						p2_d = acep_pkg::accumulate(p2_q, byte_s1[3:0]);
					else
						p1_d = acep_pkg::accumulate(p1_q, byte_s1[3:0]);
					digit_d = 1'b1;
				end else if (byte_s1 == acep_pkg::CH_SEMI) begin
					in_p2_d = 1'b1;
				end else begin
					phase_d = acep_pkg::PH_GROUND;
					case (byte_s1) inside
						acep_pkg::CMD_CUU: row_d = acep_pkg::sat_sub(row_q, p_val);
						acep_pkg::CMD_CUD: row_d = acep_pkg::sat_add(row_q, p_val);
						acep_pkg::CMD_CUF: col_d = acep_pkg::sat_add(col_q, p_val);
						acep_pkg::CMD_CUB: col_d = acep_pkg::sat_sub(col_q, p_val);
						acep_pkg::CMD_CNL: begin
							row_d = acep_pkg::sat_add(row_q, p_val);
							col_d = 8'd0;
						end
						acep_pkg::CMD_CPL: begin
							row_d = acep_pkg::sat_sub(row_q, p_val);
							col_d = 8'd0;
						end
						acep_pkg::CMD_CHA: col_d = p_val;
						acep_pkg::CMD_VPA: row_d = p_val;
						acep_pkg::CMD_CUP, acep_pkg::CMD_HVP: begin
							row_d = p_val;
							col_d = q_val;
						end
						acep_pkg::CMD_SCP: begin
							scol_d = col_q;
							srow_d = row_q;
						end
						acep_pkg::CMD_RCP: begin
							col_d = scol_q;
							row_d = srow_q;
						end
						default: ;
					endcase
				end
			end
			default: begin
				// ground, and the unused code acts the same
				phase_d = acep_pkg::PH_GROUND;
				if (byte_s1 >= acep_pkg::GLYPH_MIN && byte_s1 <= acep_pkg::GLYPH_MAX) begin
					emit = 1'b1;
					if (col_q >= wrap_col_q) begin
						glyph_col = wrap_ret_q;
						glyph_row = acep_pkg::sat_add(row_q, 8'd1);
					end
					col_d = acep_pkg::sat_add(glyph_col, 8'd1);
					row_d = glyph_row;
				end else if (byte_s1 == acep_pkg::CH_LF) begin
					row_d = acep_pkg::sat_add(row_q, 8'd1);
				end else if (byte_s1 == acep_pkg::CH_CR) begin
					col_d = 8'd0;
				end else if (byte_s1 == acep_pkg::CH_ESC) begin
					phase_d = acep_pkg::PH_ESC;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= acep_pkg::PH_GROUND;
			col_q   <= 8'd0;
			row_q   <= 8'd0;
			scol_q  <= 8'd0;
			srow_q  <= 8'd0;
			p1_q    <= 8'd0;
			p2_q    <= 8'd0;
			in_p2_q <= 1'b0;
			digit_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			col_q   <= col_d;
			row_q   <= row_d;
			scol_q  <= scol_d;
			srow_q  <= srow_d;
			p1_q    <= p1_d;
			p2_q    <= p2_d;
			in_p2_q <= in_p2_d;
			digit_q <= digit_d;
		end
	end

	// draw register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			draw_valid <= 1'b0;
		else if (advance && emit)
			draw_valid <= 1'b1;
		else if (!draw_stall)
			draw_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			glyph_code  <= byte_s1[6:0];
			draw_column <= glyph_col;
			draw_row    <= glyph_row;
		end
	end

endmodule

`default_nettype wire

@@ hdl/acep_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module acep_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       byte_valid,
	input wire logic       byte_stall,
	input wire logic       draw_valid,
	input wire logic       draw_stall,
	input wire logic [6:0] glyph_code,
	input wire logic [7:0] draw_column,
	input wire logic [7:0] draw_row
);

	// only printable codes leave the block
	`ASSERT_IMP(a_glyph_range, clk, arst_n, draw_valid, ({1'b0, glyph_code} >= acep_pkg::GLYPH_MIN && {1'b0, glyph_code} <= acep_pkg::GLYPH_MAX))

	// input backs up only behind a held draw beat
	`ASSERT_IMP(a_stall_cause, clk, arst_n, byte_stall, (draw_valid && draw_stall))

	// a fresh draw beat comes from a byte accepted earlier and passed through the input register
	`ASSERT_IMP(a_draw_source, clk, arst_n, $rose(draw_valid), $past(byte_valid && !byte_stall, 2))

	// held draw beat keeps its payload
	`ASSERT_NXT(a_draw_hold, clk, arst_n, (draw_valid && draw_stall), (draw_valid && $stable(glyph_code) && $stable(draw_column) && $stable(draw_row)))

endmodule

bind ansi_cursor_escape_parser acep_checker u_acep_checker (.*);

`default_nettype wire

@@ tb/cursor_draw_checker.sv @@
`timescale 1ns / 1ps

module cursor_draw_checker
	import acep_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       byte_valid,
	input  logic       byte_stall,
	input  logic [7:0] byte_in,
	input  logic       draw_valid,
	input  logic       draw_stall,
	input  logic [6:0] glyph_code,
	input  logic [7:0] draw_column,
	input  logic [7:0] draw_row,
	output int         fail_count,
	output int         draws_pending
);

	typedef struct packed {
		logic [6:0] glyph;
		logic [7:0] col;
		logic [7:0] row;
	} draw_cmd_t;

	draw_cmd_t due_draws[$];
	draw_cmd_t want;
	int        errs;

	logic [7:0] wrap_col, wrap_ret;
	logic [1:0] phase;
	logic [7:0] cur_col, cur_row, mark_col, mark_row;
	logic [7:0] arg_first, arg_second;
	logic       in_second, got_digit;

	function automatic logic [7:0] bump_up(input logic [7:0] v, input logic [7:0] d);
		int s;
		s = int'(v) + int'(d);
		return (s > 255) ? 8'hff : 8'(s);
	endfunction

	function automatic logic [7:0] bump_down(input logic [7:0] v, input logic [7:0] d);
		int s;
		s = int'(v) - int'(d);
		return (s < 0) ? 8'h00 : 8'(s);
	endfunction

	function automatic logic [7:0] push_digit(input logic [7:0] v, input logic [7:0] d);
		int s;
		s = int'(v) * 10 + int'(d);
		return (s > 255) ? 8'hff : 8'(s);
	endfunction

	// csi final byte: apply the command to the cursor
	task automatic run_command(input logic [7:0] b);
		logic [7:0] p, q;
		p = got_digit ? arg_first : 8'd1;
		q = got_digit ? arg_second : 8'd1;
		case (b)
			CMD_CUU: cur_row = bump_down(cur_row, p);
			CMD_CUD: cur_row = bump_up(cur_row, p);
			CMD_CUF: cur_col = bump_up(cur_col, p);
			CMD_CUB: cur_col = bump_down(cur_col, p);
			CMD_CNL: begin
				cur_row = bump_up(cur_row, p);
				cur_col = 8'd0;
			end
			CMD_CPL: begin
				cur_row = bump_down(cur_row, p);
				cur_col = 8'd0;
			end
			CMD_CHA: cur_col = p;
			CMD_VPA: cur_row = p;
			CMD_CUP, CMD_HVP: begin
				cur_row = p;
				cur_col = q;
			end
			CMD_SCP: begin
				mark_col = cur_col;
				mark_row = cur_row;
			end
			CMD_RCP: begin
				cur_col = mark_col;
				cur_row = mark_row;
			end
			default: ;
		endcase
	endtask

	task automatic track_byte(input logic [7:0] b);
		draw_cmd_t cmd;
		case (phase)
			PH_ESC: begin
				phase = PH_GROUND;
				if (b == CH_M) begin
					cur_row = bump_down(cur_row, 8'd1);
				end else if (b == CH_SAVE) begin
					mark_col = cur_col;
					mark_row = cur_row;
				end else if (b == CH_REST) begin
					cur_col = mark_col;
					cur_row = mark_row;
				end else if (b == CH_LBRK) begin
					phase = PH_CSI;
					arg_first = 8'd0;
					arg_second = 8'd0;
					in_second = 1'b0;
					got_digit = 1'b0;
				end
			end
			PH_CSI: begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					if (in_second)
						arg_second = push_digit(arg_second, b - CH_ZERO);
					else
						arg_first = push_digit(arg_first, b - CH_ZERO);
					got_digit = 1'b1;
				end else if (b == CH_SEMI) begin
					in_second = 1'b1;
				end else begin
					run_command(b);
					phase = PH_GROUND;
				end
			end
			default: begin
				phase = PH_GROUND;
				if (b >= GLYPH_MIN && b <= GLYPH_MAX) begin
					if (cur_col >= wrap_col) begin
						cur_col = wrap_ret;
						cur_row = bump_up(cur_row, 8'd1);
					end
					cmd.glyph = b[6:0];
					cmd.col = cur_col;
					cmd.row = cur_row;
					due_draws.push_back(cmd);
					cur_col = bump_up(cur_col, 8'd1);
				end else if (b == CH_LF) begin
					cur_row = bump_up(cur_row, 8'd1);
				end else if (b == CH_CR) begin
					cur_col = 8'd0;
				end else if (b == CH_ESC) begin
					phase = PH_ESC;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_col = WRAP_COL_RESET;
			wrap_ret = WRAP_RET_RESET;
			phase = PH_GROUND;
			cur_col = 8'd0;
			cur_row = 8'd0;
			mark_col = 8'd0;
			mark_row = 8'd0;
			arg_first = 8'd0;
			arg_second = 8'd0;
			in_second = 1'b0;
			got_digit = 1'b0;
			due_draws.delete();
			errs = 0;
			fail_count <= 0;
			draws_pending <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_WRAP_COL)
					wrap_col = cfg_data;
				else
					wrap_ret = cfg_data;
			end
			if (draw_valid && !draw_stall) begin
				if (due_draws.size() == 0) begin
					$error("unexpected draw beat: glyph_code %0d draw_column %0d draw_row %0d",
						glyph_code, draw_column, draw_row);
					errs++;
				end else begin
					want = due_draws.pop_front();
					if (glyph_code !== want.glyph) begin
						$error("glyph_code: expected %0d, actual %0d", want.glyph, glyph_code);
						errs++;
					end
					if (draw_column !== want.col) begin
						$error("draw_column: expected %0d, actual %0d", want.col, draw_column);
						errs++;
					end
					if (draw_row !== want.row) begin
						$error("draw_row: expected %0d, actual %0d", want.row, draw_row);
						errs++;
					end
				end
			end
			if (byte_valid && !byte_stall)
				track_byte(byte_in);
			fail_count <= errs;
			draws_pending <= due_draws.size();
		end
	end

endmodule

@@ tb/tb_ansi_cursor_escape_parser.sv @@
`timescale 1ns / 1ps

module tb_ansi_cursor_escape_parser;
	import acep_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RX_HOLD_CYCLES = 80;

	logic       clk;
	logic       arst_n;
	logic       cfg_write;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       byte_valid;
	logic       byte_stall;
	logic [7:0] byte_in;
	logic       draw_valid;
	logic       draw_stall;
	logic [6:0] glyph_code;
	logic [7:0] draw_column;
	logic [7:0] draw_row;

	int fail_count;
	int draws_pending;
	int cycle_count;

	bit tx_idle;
	bit rx_idle;
	bit rx_hold_req;

	logic [7:0] tx_bytes[$];

	ansi_cursor_escape_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_in    (byte_in),
		.draw_valid (draw_valid),
		.draw_stall (draw_stall),
		.glyph_code (glyph_code),
		.draw_column(draw_column),
		.draw_row   (draw_row)
	);

	cursor_draw_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_in      (byte_in),
		.draw_valid   (draw_valid),
		.draw_stall   (draw_stall),
		.glyph_code   (glyph_code),
		.draw_column  (draw_column),
		.draw_row     (draw_row),
		.fail_count   (fail_count),
		.draws_pending(draws_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// draw side: random stall per beat while rx_idle is set, plus one long hold on request
	initial begin : rx_side
		int n;
		draw_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				draw_stall <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end
			n = rx_idle ? $urandom_range(0, 14) : 0;
			if (n > 0) begin
				draw_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			draw_stall <= 1'b0;
			do begin
				@(posedge clk);
			end while (!draw_valid);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_in <= b;
		do begin
			@(posedge clk);
		end while (byte_stall);
	endtask

	task automatic flush_bytes;
		while (tx_bytes.size() > 0)
			send_byte(tx_bytes.pop_front());
	endtask

	// stop offering and wait until every draw beat has come out
	task automatic drain;
		byte_valid <= 1'b0;
		@(posedge clk);
		while (draws_pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_wrap(input logic [7:0] col, input logic [7:0] ret);
		write_reg(REG_WRAP_COL, col);
		write_reg(REG_WRAP_RET, ret);
	endtask

	task automatic push_number;
		int r, v;
		int digs[$];
		r = $urandom_range(0, 9);
		if (r < 5)
			v = $urandom_range(0, 9);
		else if (r < 8)
			v = $urandom_range(10, 255);
		else
			v = $urandom_range(256, 999);
		if ($urandom_range(0, 7) == 0)
			tx_bytes.push_back(CH_ZERO);
		do begin
			digs.push_front(v % 10);
			v = v / 10;
		end while (v > 0);
		foreach (digs[i])
			tx_bytes.push_back(CH_ZERO + 8'(digs[i]));
	endtask

	function automatic logic [7:0] pick_final();
		int r;
		r = $urandom_range(0, 15);
		case (r)
			0: return CMD_CUU;
			1: return CMD_CUD;
			2: return CMD_CUF;
			3: return CMD_CUB;
			4: return CMD_CNL;
			5: return CMD_CPL;
			6: return CMD_CHA;
			7: return CMD_VPA;
			8: return CMD_CUP;
			9: return CMD_HVP;
			10: return CMD_SCP;
			11: return CMD_RCP;
			12: return CH_ESC;
			13: return CH_LF;
			14: return 8'($urandom_range(0, 255));
			default: return 8'($urandom_range(GLYPH_MAX, GLYPH_MIN));
		endcase
	endfunction

	// one piece of terminal traffic: text, a control, an esc pair, a csi sequence or a random byte
	task automatic gen_chunk;
		int kind, n;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			n = $urandom_range(1, 6);
			repeat (n) tx_bytes.push_back(8'($urandom_range(GLYPH_MAX, GLYPH_MIN)));
		end else if (kind < 55) begin
			tx_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
		end else if (kind < 65) begin
			tx_bytes.push_back(CH_ESC);
			case ($urandom_range(0, 3))
				0: tx_bytes.push_back(CH_M);
				1: tx_bytes.push_back(CH_SAVE);
				2: tx_bytes.push_back(CH_REST);
				default: tx_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
		end else if (kind < 95) begin
			tx_bytes.push_back(CH_ESC);
			tx_bytes.push_back(CH_LBRK);
			case ($urandom_range(0, 5))
				0: ;
				1: push_number();
				2: begin
					push_number();
					tx_bytes.push_back(CH_SEMI);
					push_number();
				end
				3: begin
					tx_bytes.push_back(CH_SEMI);
					push_number();
				end
				4: begin
					push_number();
					tx_bytes.push_back(CH_SEMI);
				end
				default: begin
					push_number();
					tx_bytes.push_back(CH_SEMI);
					push_number();
					tx_bytes.push_back(CH_SEMI);
					push_number();
				end
			endcase
			tx_bytes.push_back(pick_final());
		end else begin
			tx_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random(input int count);
		int sent;
		sent = 0;
		while (sent < count) begin
			gen_chunk();
			sent += tx_bytes.size();
			flush_bytes();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_WRAP_COL;
		cfg_data = 8'd0;
		byte_valid = 1'b0;
		byte_in = 8'd0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		rx_hold_req = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, controls, esc pairs, saturating and default csi
		set_wrap(8'd20, 8'd3);
		tx_bytes = '{GLYPH_MIN, GLYPH_MAX, 8'h00, 8'hff, CH_LF, CH_CR,
			CH_ESC, CH_SAVE, CH_ESC, CH_M, CH_ESC, CH_REST,
			CH_ESC, CH_LBRK, CH_NINE, CH_NINE, CH_NINE, CH_SEMI, CH_ZERO + 8'd3, CMD_CUP,
			CH_ESC, CH_LBRK, CH_SEMI, CMD_HVP,
			CH_ESC, CH_LBRK, CMD_CUU, GLYPH_MIN + 8'd1};
		flush_bytes();
		drain();

		set_wrap(8'd1, 8'd255);
		run_random(100);
		drain();

		tx_idle = 1'b0;
		rx_idle = 1'b0;
		set_wrap(8'd255, 8'd0);
		run_random(100);
		drain();

		// long receiver hold while the sender keeps offering text
		tx_idle = 1'b1;
		set_wrap(8'd0, 8'd128);
		tx_idle = 1'b0;
		rx_hold_req = 1'b1;
		repeat (40) send_byte(8'($urandom_range(GLYPH_MAX, GLYPH_MIN)));
		drain();
		tx_idle = 1'b1;
		run_random(80);
		drain();

		tx_idle = 1'b0;
		rx_idle = 1'b1;
		set_wrap(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
		run_random(100);
		drain();

		tx_idle = 1'b1;
		set_wrap(WRAP_COL_RESET, WRAP_RET_RESET);
		run_random(150);
		drain();
		repeat (8) @(posedge clk);

		if (fail_count == 0 && draws_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
